// ===== sv/rrts_pkg.sv =====
// shared types and constants for the round-robin task scheduler
// no dependencies; imported by round_robin_task_scheduler_unit and the bench
package rrts_pkg;

    localparam int TASKS_DEF = 8;

    // per-slot task state codes
    typedef enum logic [1:0] {
        TS_UNUSED  = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_DEAD    = 2'd3
    } task_state_t;

    // result status codes
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_NOFREE = 3'd1;
    localparam logic [2:0] STATUS_BADID  = 3'd2;
    localparam logic [2:0] STATUS_PANIC  = 3'd3;
    localparam logic [2:0] STATUS_NORUN  = 3'd4;

    // operation codes
    localparam logic [1:0] OP_TRAP   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_KILL   = 2'd2;

    // trap cause decoding
    localparam logic [30:0] TIMER_CODE = 31'd16;
    localparam logic [31:0] ECALL_CODE = 32'd11;

    // input and result widths
    localparam int IN_W  = 80;
    localparam int OUT_W = 16;

endpackage

// ===== sv/round_robin_task_scheduler_unit.sv =====
// round-robin task scheduler: task table, running task and trap/create/kill sequencer
// depends on rrts_pkg
//
// Takes one event at a time (trap, create or kill) and answers each with exactly one
// result. The task table sits in a small memory with one read and one write port, read
// one slot per cycle, and every slot search (next ready task, first free slot) is a
// sequential scan through the read port. The shortest events are a simple trap and a bad
// kill id; the longest is a kill of the running task followed by a full scan.
// After reset all slots read as unused through per-slot valid bits, so no clearing
// pass is needed. The input side is ready again while the previous result still waits
// in the output register. An unknown exception halts the block until reset.
module round_robin_task_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int TASKS = TASKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [1:0] op, [33:2] trap_cause, [65:34] syscall_number, [73:66] target_task
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [2:0] status, [5:3] task_index, [6] switched, [7] advance_pc, [8] ack_timer
    output logic [OUT_W-1:0] m_tdata
);

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(TASKS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_KWAIT,
        S_KCHK,
        S_PICK,
        S_FILL,
        S_SCAN,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       cause_reg, cause_next;
    logic [31:0]       sysno_reg, sysno_next;
    logic [7:0]        target_reg, target_next;
    logic [IW-1:0]     addr_reg, addr_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic              create_reg, create_next;
    logic              demote_reg, demote_next;
    logic [2:0]        status_reg, status_next;
    logic              adv_reg, adv_next;
    logic              ack_reg, ack_next;
    logic              created_reg, created_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [IW-1:0]     old_idx_reg, old_idx_next;
    logic              old_valid_reg, old_valid_next;
    logic [IW-1:0]     run_idx_reg, run_idx_next;
    logic              run_valid_reg, run_valid_next;
    logic              halted_reg, halted_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // task table memory, read data registered along with its slot index
    task_state_t       task_mem [TASKS];
    logic [TASKS-1:0]  vld_reg;
    task_state_t       mem_q_reg;
    logic [IW-1:0]     q_idx_reg;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    task_state_t       wr_data;

    logic              scan_hit;
    logic              switched;
    logic [IW+2:0]     idx_ext;
    logic [IW+2:0]     run_ext;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        logic [IW-1:0] r;
        if (idx == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            task_mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= vld_reg[addr_reg] ? task_mem[addr_reg] : TS_UNUSED;
        q_idx_reg <= addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign scan_hit = create_reg ? (mem_q_reg == TS_UNUSED || mem_q_reg == TS_DEAD)
                                 : (mem_q_reg == TS_READY);

    assign switched = (old_valid_reg != run_valid_reg) ||
                      (run_valid_reg && (old_idx_reg != run_idx_reg));
    assign idx_ext  = created_reg ? {3'b000, slot_reg} : {3'b000, run_idx_reg};
    assign run_ext  = {3'b000, run_idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cause_next     = cause_reg;
        sysno_next     = sysno_reg;
        target_next    = target_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        create_next    = create_reg;
        demote_next    = demote_reg;
        status_next    = status_reg;
        adv_next       = adv_reg;
        ack_next       = ack_reg;
        created_next   = created_reg;
        slot_next      = slot_reg;
        old_idx_next   = old_idx_reg;
        old_valid_next = old_valid_reg;
        run_idx_next   = run_idx_reg;
        run_valid_next = run_valid_reg;
        halted_next    = halted_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = TS_UNUSED;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tdata[1:0];
                    cause_next  = s_tdata[33:2];
                    sysno_next  = s_tdata[65:34];
                    target_next = s_tdata[73:66];
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next    = STATUS_OK;
                adv_next       = 1'b0;
                ack_next       = 1'b0;
                created_next   = 1'b0;
                demote_next    = 1'b1;
                old_idx_next   = run_idx_reg;
                old_valid_next = run_valid_reg;
                state_next     = S_OUT;
                if (halted_reg)
                begin
                    status_next = STATUS_PANIC;
                end
                else
                begin
                    case (op_reg)
                        OP_TRAP:
                        begin
                            if (cause_reg[31])
                            begin
                                if (cause_reg[30:0] == TIMER_CODE)
                                begin
                                    ack_next   = 1'b1;
                                    state_next = S_PICK;
                                end
                            end
                            else if (cause_reg == ECALL_CODE)
                            begin
                                adv_next = 1'b1;
                                if (sysno_reg == 32'd0)
                                begin
                                    state_next = S_PICK;
                                end
                            end
                            else
                            begin
                                halted_next = 1'b1;
                                status_next = STATUS_PANIC;
                            end
                        end
                        OP_CREATE:
                        begin
                            create_next = 1'b1;
                            addr_next   = '0;
                            state_next  = S_FILL;
                        end
                        OP_KILL:
                        begin
                            if (target_reg >= 8'(TASKS))
                            begin
                                status_next = STATUS_BADID;
                            end
                            else
                            begin
                                addr_next  = target_reg[IW-1:0];
                                state_next = S_KWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_KWAIT:
            begin
                state_next = S_KCHK;
            end

            S_KCHK:
            begin
                state_next = S_OUT;
                if (mem_q_reg == TS_READY || mem_q_reg == TS_RUNNING)
                begin
                    wr_en   = 1'b1;
                    wr_addr = q_idx_reg;
                    wr_data = TS_DEAD;
                    if (run_valid_reg && (run_idx_reg == q_idx_reg))
                    begin
                        // killed slot stays dead, no demotion before the search
                        demote_next = 1'b0;
                        state_next  = S_PICK;
                    end
                end
            end

            S_PICK:
            begin
                if (demote_reg && run_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = run_idx_reg;
                    wr_data = TS_READY;
                end
                create_next = 1'b0;
                addr_next   = next_slot(run_idx_reg);
                state_next  = S_FILL;
            end

            S_FILL:
            begin
                addr_next  = next_slot(addr_reg);
                cnt_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                addr_next = next_slot(addr_reg);
                if (scan_hit)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = q_idx_reg;
                    state_next = S_OUT;
                    if (create_reg)
                    begin
                        wr_data      = TS_READY;
                        created_next = 1'b1;
                        slot_next    = q_idx_reg;
                    end
                    else
                    begin
                        wr_data        = TS_RUNNING;
                        run_idx_next   = q_idx_reg;
                        run_valid_next = 1'b1;
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_OUT;
                    if (create_reg)
                    begin
                        status_next = STATUS_NOFREE;
                    end
                    else
                    begin
                        run_valid_next = 1'b0;
                        status_next    = STATUS_NORUN;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (halted_reg && status_reg == STATUS_PANIC)
                    begin
                        // halted: only status and running index are reported
                        m_tdata_next = {7'd0, 1'b0, 1'b0, 1'b0, run_ext[2:0], STATUS_PANIC};
                    end
                    else
                    begin
                        m_tdata_next = {7'd0, ack_reg, adv_reg, switched, idx_ext[2:0],
                                        status_reg};
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_idx_reg   <= '0;
            run_valid_reg <= 1'b0;
            halted_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            create_reg    <= 1'b0;
            demote_reg    <= 1'b0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            run_idx_reg   <= run_idx_next;
            run_valid_reg <= run_valid_next;
            halted_reg    <= halted_next;
            m_tvalid_reg  <= m_tvalid_next;
            create_reg    <= create_next;
            demote_reg    <= demote_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
        end
    end

    // transaction payload and per-item scratch, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cause_reg     <= cause_next;
        sysno_reg     <= sysno_next;
        target_reg    <= target_next;
        status_reg    <= status_next;
        adv_reg       <= adv_next;
        ack_reg       <= ack_next;
        created_reg   <= created_next;
        slot_reg      <= slot_next;
        old_idx_reg   <= old_idx_next;
        old_valid_reg <= old_valid_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for round_robin_task_scheduler_unit: directed table, random events, final halt
// uses rrts_pkg for codes and widths; tracks the task table in its own scheduler model
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrts_pkg::*;

    localparam int TASKS = TASKS_DEF;
    localparam int RANDOM_EVENTS = 1900;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [31:0] TIMER_IRQ = {1'b1, TIMER_CODE};
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] cause;
        logic [31:0] sysno;
        logic [7:0]  target;
    } sched_event_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot;
        logic       switched;
        logic       advance_pc;
        logic       ack_timer;
    } sched_result_t;

    typedef struct packed {
        sched_event_t  ev;
        logic          has_exp;
        sched_result_t exp;
    } dir_row_t;

    localparam sched_result_t NO_EXP = '0;

    // expected results given only where obvious; others come from the scheduler model
    localparam dir_row_t DIRECTED_ROWS [24] = '{
        '{'{OP_TRAP, TIMER_IRQ, 32'd0, 8'd0}, 1'b1, '{STATUS_NORUN, 3'd0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_TRAP, ECALL_CODE, 32'd0, 8'd0}, 1'b1, '{STATUS_NORUN, 3'd0, 1'b0, 1'b1, 1'b0}},
        '{'{OP_KILL, 32'd0, 32'd0, 8'hFF}, 1'b1, '{STATUS_BADID, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_KILL, 32'd0, 32'd0, 8'd8}, 1'b1, '{STATUS_BADID, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_KILL, 32'd0, 32'd0, 8'd0}, 1'b1, '{STATUS_OK, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b1, '{STATUS_OK, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_CREATE, ALL_ONES, ALL_ONES, 8'hFF}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b1, '{STATUS_NOFREE, 3'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TRAP, TIMER_IRQ, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_TRAP, ECALL_CODE, ALL_ONES, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_TRAP, ALL_ONES, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_TRAP, 32'h8000_0000, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_KILL, 32'd0, 32'd0, 8'd1}, 1'b0, NO_EXP},
        '{'{OP_KILL, 32'd0, 32'd0, 8'd7}, 1'b0, NO_EXP},
        '{'{OP_KILL, 32'd0, 32'd0, 8'd1}, 1'b0, NO_EXP},
        '{'{OP_NONE, ALL_ONES, ALL_ONES, 8'hFF}, 1'b0, NO_EXP},
        '{'{OP_CREATE, 32'd0, 32'd0, 8'd0}, 1'b0, NO_EXP},
        '{'{OP_TRAP, ECALL_CODE, 32'd0, 8'd0}, 1'b0, NO_EXP}
    };

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // scheduler model state
    task_state_t slot_state [TASKS];
    logic [2:0]  run_slot;
    logic        run_valid;
    logic        sched_halted;

    sched_result_t expected_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          results_seen = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    round_robin_task_scheduler_unit #(.TASKS(TASKS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // round-robin search from the slot after the running one; current task goes to the back
    function automatic bit switch_to_next();
        int s;
        if (run_valid && slot_state[run_slot] == TS_RUNNING)
            slot_state[run_slot] = TS_READY;
        for (int i = 0; i < TASKS; i++)
        begin
            s = (int'(run_slot) + 1 + i) % TASKS;
            if (slot_state[s] == TS_READY)
            begin
                slot_state[s] = TS_RUNNING;
                run_slot = s[2:0];
                run_valid = 1'b1;
                return 1'b1;
            end
        end
        run_valid = 1'b0;
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_schedule(input sched_event_t ev);
        sched_result_t r;
        logic [2:0]    old_slot;
        logic          old_valid;
        logic          created;
        logic [2:0]    new_slot;
        logic          was_running;
        r = '0;
        r.status = STATUS_OK;
        old_slot = run_slot;
        old_valid = run_valid;
        created = 1'b0;
        new_slot = '0;
        if (sched_halted)
            r.status = STATUS_PANIC;
        else
        begin
            case (ev.op)
                OP_TRAP:
                begin
                    if (ev.cause[31])
                    begin
                        if (ev.cause[30:0] == TIMER_CODE)
                        begin
                            r.ack_timer = 1'b1;
                            if (!switch_to_next())
                                r.status = STATUS_NORUN;
                        end
                    end
                    else if (ev.cause == ECALL_CODE)
                    begin
                        r.advance_pc = 1'b1;
                        if (ev.sysno == 32'd0)
                        begin
                            if (!switch_to_next())
                                r.status = STATUS_NORUN;
                        end
                    end
                    else
                    begin
                        sched_halted = 1'b1;
                        r.status = STATUS_PANIC;
                    end
                end
                OP_CREATE:
                begin
                    for (int i = 0; i < TASKS; i++)
                    begin
                        if (!created && (slot_state[i] == TS_UNUSED || slot_state[i] == TS_DEAD))
                        begin
                            slot_state[i] = TS_READY;
                            created = 1'b1;
                            new_slot = i[2:0];
                        end
                    end
                    if (!created)
                        r.status = STATUS_NOFREE;
                end
                OP_KILL:
                begin
                    if (ev.target >= TASKS)
                        r.status = STATUS_BADID;
                    else if (slot_state[ev.target] == TS_READY ||
                             slot_state[ev.target] == TS_RUNNING)
                    begin
                        was_running = run_valid && (run_slot == ev.target[2:0]);
                        slot_state[ev.target] = TS_DEAD;
                        if (was_running)
                        begin
                            if (!switch_to_next())
                                r.status = STATUS_NORUN;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.slot = created ? new_slot : run_slot;
        r.switched = (old_valid != run_valid) || (run_valid && old_slot != run_slot);
        return r;
    endfunction

    // mostly well-formed events that keep the block alive; no unknown exceptions here
    function automatic sched_event_t random_event();
        sched_event_t ev;
        int pick;
        pick = $urandom_range(0, 99);
        ev.op = OP_TRAP;
        ev.cause = $urandom;
        ev.sysno = $urandom;
        ev.target = 8'($urandom_range(0, 255));
        if (pick < 24)
            ev.op = OP_CREATE;
        else if (pick < 48)
        begin
            ev.op = OP_KILL;
            if ($urandom_range(0, 9) != 0)
                ev.target = 8'($urandom_range(0, TASKS - 1));
        end
        else if (pick < 70)
            ev.cause = TIMER_IRQ;
        else if (pick < 86)
        begin
            ev.cause = ECALL_CODE;
            ev.sysno = 32'd0;
        end
        else if (pick < 92)
            ev.cause = ECALL_CODE;
        else if (pick < 97)
            ev.cause[31] = 1'b1;
        else
            ev.op = OP_NONE;
        return ev;
    endfunction

    // returns at the edge where the transaction is taken
    task automatic send_event(input sched_event_t ev);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_W - 74){1'b0}}, ev.target, ev.sysno, ev.cause, ev.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic check_result(input logic [OUT_W-1:0] raw);
        sched_result_t got;
        sched_result_t want;
        got = '{raw[2:0], raw[5:3], raw[6], raw[7], raw[8]};
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d slot=%0d sw=%0b adv=%0b ack=%0b",
                     $time, got.status, got.slot, got.switched, got.advance_pc,
                     got.ack_timer);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got !== want)
            begin
                $display({"%0t: mismatch expected status=%0d slot=%0d sw=%0b adv=%0b ",
                          "ack=%0b, got status=%0d slot=%0d sw=%0b adv=%0b ack=%0b"},
                         $time, want.status, want.slot, want.switched, want.advance_pc,
                         want.ack_timer, got.status, got.slot, got.switched,
                         got.advance_pc, got.ack_timer);
                error_count++;
            end
        end
    endtask

    task automatic drain_results();
        int gap;
        forever
        begin
            if (results_seen % 64 == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
            gap = receiver_quiet ? 0 : $urandom_range(0, 16);
            // one long hold-off so the output register fills and the input stalls
            if (results_seen == 500)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_result(m_tdata);
            results_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("round_robin_task_scheduler_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        sched_event_t  ev;
        sched_result_t want;
        for (int i = 0; i < TASKS; i++)
            slot_state[i] = TS_UNUSED;
        run_slot = '0;
        run_valid = 1'b0;
        sched_halted = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_event(DIRECTED_ROWS[i].ev);
            want = predict_schedule(DIRECTED_ROWS[i].ev);
            if (DIRECTED_ROWS[i].has_exp)
                want = DIRECTED_ROWS[i].exp;
            expected_results.push_back(want);
        end

        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            if (n % 64 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            if (n == 900)
            begin
                // let the block run completely dry once
                s_tvalid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge clk);
            end
            ev = random_event();
            send_event(ev);
            expected_results.push_back(predict_schedule(ev));
        end

        // unknown exception halts the block; later events only answer panic
        ev = random_event();
        ev.op = OP_TRAP;
        ev.cause[31] = 1'b0;
        if (ev.cause == ECALL_CODE)
            ev.cause = 32'd0;
        send_event(ev);
        expected_results.push_back(predict_schedule(ev));
        for (int n = 0; n < 8; n++)
        begin
            ev = random_event();
            send_event(ev);
            expected_results.push_back(predict_schedule(ev));
        end
        s_tvalid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("round_robin_task_scheduler_unit regression: pass");
        else
            $display("round_robin_task_scheduler_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rrts_pkg.sv
sv/round_robin_task_scheduler_unit.sv
bench/tb.sv
